FILE: rtl/mrhs_pkg.sv
// package for the memory range hazard scoreboard
// holds the kind codes, range and cell control types shared by the cells and the top level
`timescale 1ns / 1ps

package mrhs_pkg;

    localparam int DEFAULT_CAPACITY = 256;

    localparam int KIND_W = 2;
    localparam int ID_W   = 64;
    localparam int ADDR_W = 64;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   buffer_id;
        logic [ADDR_W-1:0] range_begin;
        logic [ADDR_W-1:0] range_end;
        logic              is_write;
    } range_t;

    typedef struct packed {
        logic clear;  // zero the running conflict flag
        logic step;   // move the conflict flag one cell down the row
    } cell_ctrl_t;

endpackage

FILE: rtl/mrhs_cell.sv
// one scoreboard cell: a stored range, its conflict test and one stage of the flag chain
// depends on mrhs_pkg
`timescale 1ns / 1ps

module mrhs_cell
    import mrhs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  range_t     entry_in,
    input  logic       active,
    input  range_t     query,
    input  cell_ctrl_t ctrl,
    input  logic       hit_in,
    output logic       hit_out
);

    range_t entry_reg;
    logic   hit_reg;
    logic   hit_next;
    logic   match;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= entry_in;
        end
    end

    // inclusive end test kept as specified
    assign match = active
                && (query.buffer_id == entry_reg.buffer_id)
                && (query.is_write || entry_reg.is_write)
                && (query.range_begin < entry_reg.range_end)
                && (query.range_end >= entry_reg.range_begin);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            hit_next = hit_in || match;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit_out = hit_reg;

endmodule

FILE: rtl/memory_range_hazard_scoreboard.sv
// top level of the memory range hazard scoreboard: row of range cells plus sequencer
// depends on mrhs_pkg and mrhs_cell
// result: add, clear and unknown kinds give their registered result in the cycle after the transfer
// check: the conflict flag walks the row one cell a cycle, then waits for a free output register
// throughput: one add or clear per cycle unless the output stalls; none taken during a check
// reset: rst_n clears the entry count, sequencer and output valid; stored ranges are not cleared
`timescale 1ns / 1ps

module memory_range_hazard_scoreboard
    import mrhs_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [ID_W-1:0]   buffer_id,
    input  logic [ADDR_W-1:0] range_begin,
    input  logic [ADDR_W-1:0] range_end,
    input  logic              is_write,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              no_conflict,
    output logic              table_full
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              no_conflict_reg, no_conflict_next;
    logic              table_full_reg, table_full_next;
    range_t            query_reg;

    range_t     item;
    cell_ctrl_t ctrl;
    logic       in_fire;
    logic       out_free;
    logic       add_fire;
    logic [CAPACITY:0] hit_chain;

    assign item = '{buffer_id: buffer_id, range_begin: range_begin,
                    range_end: range_end, is_write: is_write};

    // output register frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign add_fire = in_fire && (kind == KIND_ADD) && (count_reg != FULL_CNT);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        no_conflict_next = no_conflict_reg;
        table_full_next  = table_full_reg;
        ctrl             = '{clear: 1'b0, step: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (kind)
                        KIND_ADD:
                        begin
                            out_valid_next   = 1'b1;
                            no_conflict_next = 1'b1;
                            if (count_reg != FULL_CNT)
                            begin
                                count_next      = count_reg + CNT_W'(1);
                                table_full_next = 1'b0;
                            end
                            else
                            begin
                                // range dropped, table unchanged
                                table_full_next = 1'b1;
                            end
                        end
                        KIND_CHECK:
                        begin
                            ctrl.clear = 1'b1;
                            step_next  = '0;
                            state_next = ST_SCAN;
                        end
                        KIND_CLEAR:
                        begin
                            count_next       = '0;
                            out_valid_next   = 1'b1;
                            no_conflict_next = 1'b1;
                            table_full_next  = 1'b0;
                        end
                        default:
                        begin
                            // unknown kind leaves the table alone
                            out_valid_next   = 1'b1;
                            no_conflict_next = 1'b1;
                            table_full_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // every step the flag in each cell folds in that cell's match
                ctrl.step = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // last cell now holds the or of all matches
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    no_conflict_next = !hit_chain[CAPACITY];
                    table_full_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        no_conflict_reg <= no_conflict_next;
        table_full_reg  <= table_full_next;
        if (in_fire && (kind == KIND_CHECK))
        begin
            query_reg <= item;
        end
    end

    // row of cells, the conflict flag enters at the head with nothing seen
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic load;
        logic active;

        // the add transfer fills the first free cell
        assign load   = add_fire && (count_reg == CNT_W'(i));
        assign active = CNT_W'(i) < count_reg;

        mrhs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .entry_in (item),
            .active   (active),
            .query    (query_reg),
            .ctrl     (ctrl),
            .hit_in   (hit_chain[i]),
            .hit_out  (hit_chain[i+1])
        );
    end

    assign out_valid   = out_valid_reg;
    assign no_conflict = no_conflict_reg;
    assign table_full  = table_full_reg;

endmodule

FILE: tb/sv/testbench.sv
// testbench for memory_range_hazard_scoreboard: directed cases, a full table, random range traffic
// predicts every verdict from a private copy of the range table; depends on mrhs_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
    import mrhs_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_CAPACITY;
    // slowest legal run is about 1200 items, each a check walking the whole row plus stalls;
    // this leaves several times that margin
    localparam int CYCLE_LIMIT = 2_000_000;
    // the drain wait outlasts a check walking the whole row, to catch stray results
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int RANDOM_ITEMS_PER_PHASE = 310;

    // the fourth kind code has no meaning and must leave the table alone
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [ID_W-1:0]   ID_ONES     = '1;
    localparam logic [ADDR_W-1:0] ADDR_ONES   = '1;

    typedef struct packed {
        logic no_conflict;
        logic table_full;
    } verdict_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [KIND_W-1:0] kind        = KIND_ADD;
    logic [ID_W-1:0]   buffer_id   = '0;
    logic [ADDR_W-1:0] range_begin = '0;
    logic [ADDR_W-1:0] range_end   = '0;
    logic              is_write    = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              no_conflict;
    logic              table_full;

    // private copy of the range table, filled in transfer order
    logic [ID_W-1:0]   shadow_id    [TABLE_DEPTH];
    logic [ADDR_W-1:0] shadow_begin [TABLE_DEPTH];
    logic [ADDR_W-1:0] shadow_end   [TABLE_DEPTH];
    logic              shadow_write [TABLE_DEPTH];
    int                shadow_count = 0;

    verdict_t expected_verdicts [$];
    int       error_count   = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    // small pools so random checks often land on stored buffers and nearby addresses
    logic [ID_W-1:0]   id_pool   [4];
    logic [ADDR_W-1:0] base_pool [3];

    memory_range_hazard_scoreboard #(
        .CAPACITY (TABLE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .buffer_id   (buffer_id),
        .range_begin (range_begin),
        .range_end   (range_end),
        .is_write    (is_write),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .no_conflict (no_conflict),
        .table_full  (table_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // any stored entry on the same buffer, not both reads, overlapping with the inclusive end test
    function automatic logic range_hits_table(input logic [ID_W-1:0] id,
                                              input logic [ADDR_W-1:0] b,
                                              input logic [ADDR_W-1:0] e,
                                              input logic wr);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_id[i] == id && (wr || shadow_write[i]) &&
                b < shadow_end[i] && e >= shadow_begin[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // update the shadow table for one transfer and return the verdict it must produce
    function automatic verdict_t apply_range_item(input logic [KIND_W-1:0] k,
                                                  input logic [ID_W-1:0] id,
                                                  input logic [ADDR_W-1:0] b,
                                                  input logic [ADDR_W-1:0] e,
                                                  input logic wr);
        verdict_t v;
        v.no_conflict = 1'b1;
        v.table_full  = 1'b0;
        case (k)
            KIND_ADD:
            begin
                if (shadow_count < TABLE_DEPTH)
                begin
                    shadow_id[shadow_count]    = id;
                    shadow_begin[shadow_count] = b;
                    shadow_end[shadow_count]   = e;
                    shadow_write[shadow_count] = wr;
                    shadow_count++;
                end
                else
                    v.table_full = 1'b1;   // dropped, table untouched
            end
            KIND_CHECK: v.no_conflict = !range_hits_table(id, b, e, wr);
            KIND_CLEAR: shadow_count = 0;
            default: ;
        endcase
        return v;
    endfunction

    // one input transfer: optional idle gap, then hold valid and payload until accepted
    task automatic send_range(input logic [KIND_W-1:0] k,
                              input logic [ID_W-1:0] id,
                              input logic [ADDR_W-1:0] b,
                              input logic [ADDR_W-1:0] e,
                              input logic wr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind        = k;
        buffer_id   = id;
        range_begin = b;
        range_end   = e;
        is_write    = wr;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        expected_verdicts.insert(expected_verdicts.size(), apply_range_item(k, id, b, e, wr));
        @(negedge clk);
    endtask

    // result checker: every accepted result against the oldest expected verdict
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: result with none expected, no_conflict %0b table_full %0b",
                         $time, no_conflict, table_full);
                error_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (no_conflict !== want.no_conflict)
                begin
                    $display("%0t: no_conflict expected %0b actual %0b",
                             $time, want.no_conflict, no_conflict);
                    error_count++;
                end
                if (table_full !== want.table_full)
                begin
                    $display("%0t: table_full expected %0b actual %0b",
                             $time, want.table_full, table_full);
                    error_count++;
                end
            end
        end
    end

    // every kind, read/write pairing, both edges of the overlap test, reversed range
    task automatic test_basic_hazards();
        logic [ID_W-1:0] buf_a;
        logic [ID_W-1:0] buf_b;
        buf_a = rand64();
        buf_b = ~buf_a;
        send_range(KIND_CHECK, buf_a, 64'd150, 64'd160, 1'b1);   // empty table
        send_range(KIND_CLEAR, buf_a, 64'd0, 64'd0, 1'b0);
        send_range(KIND_ADD,   buf_a, 64'd100, 64'd200, 1'b0);   // stored read
        send_range(KIND_CHECK, buf_a, 64'd150, 64'd160, 1'b0);   // read after read
        send_range(KIND_CHECK, buf_a, 64'd150, 64'd160, 1'b1);   // write after read
        send_range(KIND_CHECK, buf_b, 64'd150, 64'd160, 1'b1);   // other buffer
        send_range(KIND_CHECK, buf_a, 64'd200, 64'd300, 1'b1);   // starts at entry end
        send_range(KIND_CHECK, buf_a, 64'd50, 64'd100, 1'b1);    // ends at entry begin
        send_range(KIND_CHECK, buf_a, 64'd50, 64'd99, 1'b1);     // just below
        send_range(KIND_ADD,   buf_a, 64'd300, 64'd400, 1'b1);   // stored write
        send_range(KIND_CHECK, buf_a, 64'd350, 64'd351, 1'b0);   // read after write
        send_range(KIND_ADD,   buf_a, 64'd500, 64'd450, 1'b1);   // reversed range
        send_range(KIND_CHECK, buf_a, 64'd440, 64'd520, 1'b0);
        send_range(KIND_CHECK, buf_a, 64'd460, 64'd470, 1'b0);
        send_range(KIND_UNUSED, buf_a, 64'd0, ADDR_ONES, 1'b1);  // ignored
        send_range(KIND_CHECK, buf_a, 64'd0, ADDR_ONES, 1'b1);
        send_range(KIND_CLEAR, buf_b, rand64(), rand64(), 1'b1);
        send_range(KIND_CHECK, buf_a, 64'd150, 64'd160, 1'b1);   // table empty again
    endtask

    // all-zero and all-one ids and addresses
    task automatic test_field_extremes();
        send_range(KIND_ADD,   ID_ONES, 64'd0, ADDR_ONES, 1'b1);
        send_range(KIND_ADD,   64'd0, ADDR_ONES, 64'd0, 1'b0);
        send_range(KIND_CHECK, ID_ONES, ADDR_ONES, ADDR_ONES, 1'b0);
        send_range(KIND_CHECK, ID_ONES, ADDR_ONES - 1, 64'd0, 1'b0);
        send_range(KIND_CHECK, 64'd0, 64'd0, ADDR_ONES, 1'b1);
        send_range(KIND_CHECK, 64'd0, ADDR_ONES, ADDR_ONES, 1'b1);
        send_range(KIND_CHECK, ID_ONES, 64'd0, 64'd0, 1'b1);
        send_range(KIND_CLEAR, ID_ONES, ADDR_ONES, ADDR_ONES, 1'b1);
    endtask

    // fill every cell, overflow once, make sure the last cell takes part in checks
    task automatic test_table_full();
        logic [ID_W-1:0] last_id;
        last_id = rand64();
        for (int i = 0; i < TABLE_DEPTH - 1; i++)
            send_range(KIND_ADD, rand64(), rand64(), rand64(), 1'($urandom_range(1)));
        send_range(KIND_ADD,    last_id, 64'h1000, 64'h2000, 1'b1);
        send_range(KIND_ADD,    last_id, 64'h3000, 64'h4000, 1'b1);   // dropped
        send_range(KIND_UNUSED, last_id, 64'h0, ADDR_ONES, 1'b0);
        send_range(KIND_CHECK,  last_id, 64'h1800, 64'h1900, 1'b0);   // hits last cell
        send_range(KIND_CHECK,  last_id, 64'h3800, 64'h3900, 1'b0);   // dropped range absent
        send_range(KIND_CLEAR,  last_id, 64'h0, 64'h0, 1'b0);
        send_range(KIND_ADD,    last_id, 64'h3000, 64'h4000, 1'b1);   // room again
        send_range(KIND_CHECK,  last_id, 64'h3800, 64'h3900, 1'b0);
    endtask

    // mostly ranges near shared bases on pooled buffers, some fully random noise
    task automatic send_random_item();
        int                sel;
        logic [KIND_W-1:0] k;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] e;
        sel = $urandom_range(99);
        if (sel < 50)
            k = KIND_ADD;
        else if (sel < 95)
            k = KIND_CHECK;
        else if (sel < 97)
            k = KIND_CLEAR;
        else
            k = KIND_UNUSED;
        id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(3)] : rand64();
        if ($urandom_range(99) < 80)
        begin
            b = base_pool[$urandom_range(2)] + 64'($urandom_range(63));
            if ($urandom_range(99) < 10)
                e = b - 64'($urandom_range(8, 1));   // reversed range
            else
                e = b + 64'($urandom_range(16));
        end
        else
        begin
            b = rand64();
            e = rand64();
        end
        send_range(k, id, b, e, 1'($urandom_range(1)));
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (RANDOM_ITEMS_PER_PHASE)
            send_random_item();
    endtask

    initial
    begin
        id_pool[0]   = '0;
        id_pool[1]   = ID_ONES;
        id_pool[2]   = rand64();
        id_pool[3]   = rand64();
        base_pool[0] = '0;
        base_pool[1] = ADDR_ONES - 63;
        base_pool[2] = rand64();

        send_idle_pct = 34;
        recv_idle_pct = 55;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_hazards();
        test_field_extremes();
        test_table_full();
        test_random_traffic(34, 55);
        test_random_traffic(55, 34);
        test_random_traffic(0, 0);
        in_valid = 1'b0;

        // drain, then give a stray result time to show up
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
